// ----- hw/rtl/dplm_pkg.sv -----
package dplm_pkg;

	localparam int PROCS_DEF  = 4;
	localparam int PAGES_DEF  = 32;
	localparam int FRAMES_DEF = 64;

	localparam int NUM_LIMIT_REGS = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;
	localparam int LIMIT_W        = 6;
	localparam int STAMP_W        = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_P0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_P3      = 3'd4;

	localparam logic [CFG_DATA_W-1:0] FRAMES_IN_USE_RST = 7'd64;
	localparam logic [LIMIT_W-1:0]    PAGE_LIMIT_RST    = 6'd32;
	localparam logic [LIMIT_W-1:0]    PAGE_LIMIT_ABSENT = 6'd32;

	// outcome codes
	localparam logic [2:0] OUT_HIT       = 3'd0;
	localparam logic [2:0] OUT_FAULT     = 3'd1;
	localparam logic [2:0] OUT_KILLED    = 3'd2;
	localparam logic [2:0] OUT_ENDED     = 3'd3;
	localparam logic [2:0] OUT_NO_VICTIM = 3'd4;

	typedef struct packed {
		logic       mode;
		logic [1:0] process;
		logic [7:0] page;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [5:0]  frame;
		logic [31:0] fault_count;
		logic [2:0]  live_processes;
	} out_item_t;

endpackage

// ----- hw/rtl/demand_paging_lru_mmu_top.sv -----
// channel  | signals                     | transfer when
// ---------+-----------------------------+-------------------------
// in       | in_valid in_ready in_item   | in_valid && in_ready
// out      | out_valid out_ready out_item| out_valid && out_ready
// cfg      | cfg_we cfg_index cfg_data   | cfg_we
// One item at a time; in_ready is high only while the sequencer is idle.
// A hit or a fault on a free frame needs no scan. An eviction first runs a
// last-use scan through the page table memory (one read per cycle).
// End or kill: frame release, then the quota share in the shared serial divider.
// The first item after reset also runs the quota share. A stalled result sits in
// the output register while the next item is already taken.
module demand_paging_lru_mmu_top #(
	parameter int PROCS  = dplm_pkg::PROCS_DEF,
	parameter int PAGES  = dplm_pkg::PAGES_DEF,
	parameter int FRAMES = dplm_pkg::FRAMES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dplm_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_ready,
	output dplm_pkg::out_item_t                out_item,
	input  logic                               cfg_we,
	input  logic [dplm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dplm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dplm_pkg::*;

	localparam int NE   = PROCS * PAGES;
	localparam int AW   = NE > 1 ? $clog2(NE) : 1;
	localparam int PIW  = PROCS > 1 ? $clog2(PROCS) : 1;
	localparam int KW   = $clog2(PROCS + 1);
	localparam int PGW  = PAGES > 1 ? $clog2(PAGES) : 1;
	localparam int PCW  = $clog2(PAGES + 1);
	localparam int WW   = $clog2(PAGES + 1);
	localparam int FW   = FRAMES > 1 ? $clog2(FRAMES) : 1;
	localparam int FCW  = $clog2(FRAMES + 1);
	localparam int QW   = FCW;
	localparam int GW   = $clog2(FRAMES + PROCS + 1);
	localparam int TW   = $clog2(PROCS * PAGES + 1);
	localparam int NW   = FCW + WW;
	localparam int DCW  = $clog2(NW + 1);
	localparam int EW   = FW + STAMP_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_HIT, S_POP, S_SCAN, S_SCAN_END, S_REL, S_REL_PUSH,
		S_RS_INIT, S_RS_PROC, S_RS_DIV, S_RS_STORE, S_RS_FIX, S_FINISH
	} state_t;

	typedef struct packed {
		logic [FW-1:0]      frame;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	state_t state_q;

	// configuration
	logic [CFG_DATA_W-1:0] frames_in_use_q;
	logic [LIMIT_W-1:0]    page_limit_q [NUM_LIMIT_REGS];

	// item
	logic           mode_q;
	logic [1:0]     proc_q;
	logic [7:0]     page_q;

	// block state
	logic [NE-1:0]      ev_q;
	logic [FRAMES-1:0]  fs_vld_q;
	logic [FCW-1:0]     free_top_q;
	logic [QW-1:0]      quota_q [PROCS];
	logic [QW-1:0]      held_q [PROCS];
	logic [PROCS-1:0]   ended_q;
	logic [STAMP_W-1:0] clock_q;
	logic [31:0]        faults_q [PROCS];
	logic               quotas_ready_q;

	// sequencer work registers
	logic [PCW-1:0]     i_q;
	logic               pend_s1;
	logic [PGW-1:0]     idx_s1;
	logic               found_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [PGW-1:0]     victim_q;
	logic [FW-1:0]      vframe_q;
	logic               fs_vld_s1;
	logic [FW-1:0]      ft_s1;
	logic [2:0]         outcome_q;
	logic [FW-1:0]      frame_q;

	// quota share
	logic               rs_ret_q;
	logic [KW-1:0]      k_q;
	logic [GW-1:0]      given_q;
	logic [PIW-1:0]     bi_q;
	logic [TW-1:0]      tot_q;
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      quot_q;
	logic [TW:0]        rem_q;
	logic [DCW-1:0]     dcnt_q;

	logic               out_valid_q;
	out_item_t          out_q;

	// combinational views
	logic [FCW-1:0]     f_eff;
	logic [WW-1:0]      wlim [PROCS];
	logic [TW-1:0]      tot;
	logic [PIW-1:0]     best_idx;
	logic [WW-1:0]      best_w;
	logic               p_ok;
	logic [PIW-1:0]     p_idx;
	logic [AW-1:0]      e_addr;
	logic [AW-1:0]      i_addr;
	logic [2:0]         live;
	logic [TW:0]        trial;

	logic               em_we;
	logic [AW-1:0]      em_waddr;
	entry_t             em_wdata;
	logic [AW-1:0]      em_raddr;
	entry_t             em_rdata;
	logic               fs_we;
	logic [FW-1:0]      fs_waddr;
	logic [FW-1:0]      fs_wdata;
	logic [FW-1:0]      fs_raddr;
	logic [FW-1:0]      fs_rdata;

	function automatic logic [AW-1:0] ent(input logic [PIW-1:0] pp, input logic [PGW-1:0] pg);
		return AW'(32'(pp) * PAGES + 32'(pg));
	endfunction

	always_comb begin
		logic [LIMIT_W-1:0] raw;
		f_eff = (32'(frames_in_use_q) < FRAMES) ? FCW'(frames_in_use_q) : FCW'(FRAMES);
		tot = '0;
		best_idx = '0;
		best_w = '0;
		live = '0;
		for (int k = 0; k < PROCS; k++) begin
			raw = (k < NUM_LIMIT_REGS) ? page_limit_q[k % NUM_LIMIT_REGS] : PAGE_LIMIT_ABSENT;
			wlim[k] = (32'(raw) < PAGES) ? WW'(raw) : WW'(PAGES);
			if (!ended_q[k]) begin
				tot = tot + TW'(wlim[k]);
				live = live + 3'd1;
				if (wlim[k] > best_w) begin
					best_w = wlim[k];
					best_idx = PIW'(k);
				end
			end
		end
	end

	assign p_ok   = 32'(proc_q) < PROCS;
	assign p_idx  = PIW'(proc_q);
	assign e_addr = ent(p_idx, PGW'(page_q));
	assign i_addr = ent(p_idx, PGW'(i_q));
	assign trial  = {rem_q[TW-1:0], num_q[NW-1]};

	// memory port control
	always_comb begin
		em_we    = 1'b0;
		em_waddr = e_addr;
		em_wdata = '{frame: em_rdata.frame, stamp: clock_q};
		em_raddr = e_addr;
		fs_we    = 1'b0;
		fs_waddr = FW'(free_top_q - FCW'(1));
		fs_wdata = em_rdata.frame;
		fs_raddr = FW'(free_top_q);
		unique case (state_q)
			S_HIT: begin
				em_we = 1'b1;
			end
			S_POP: begin
				em_we = 1'b1;
				em_wdata.frame = fs_vld_s1 ? fs_rdata : ft_s1;
			end
			S_SCAN, S_REL: begin
				em_raddr = i_addr;
			end
			S_SCAN_END: begin
				em_we = found_q;
				em_wdata.frame = vframe_q;
			end
			S_REL_PUSH: begin
				fs_we = free_top_q != '0;
			end
			default: begin
			end
		endcase
	end

	dplm_ram #(.WIDTH(EW), .DEPTH(NE)) u_entry_ram (
		.clk   (clk),
		.we    (em_we),
		.waddr (em_waddr),
		.wdata (em_wdata),
		.raddr (em_raddr),
		.rdata (em_rdata)
	);

	dplm_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			frames_in_use_q <= FRAMES_IN_USE_RST;
			for (int k = 0; k < NUM_LIMIT_REGS; k++) page_limit_q[k] <= PAGE_LIMIT_RST;
			ev_q            <= '0;
			fs_vld_q        <= '0;
			free_top_q      <= '0;
			for (int k = 0; k < PROCS; k++) begin
				quota_q[k]  <= '0;
				held_q[k]   <= '0;
				faults_q[k] <= '0;
			end
			ended_q         <= '0;
			clock_q         <= '0;
			quotas_ready_q  <= 1'b0;
			pend_s1         <= 1'b0;
			found_q         <= 1'b0;
			rs_ret_q        <= 1'b0;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
			mode_q          <= 1'b0;
			proc_q          <= '0;
			page_q          <= '0;
			i_q             <= '0;
			idx_s1          <= '0;
			oldest_q        <= '0;
			victim_q        <= '0;
			vframe_q        <= '0;
			fs_vld_s1       <= 1'b0;
			ft_s1           <= '0;
			outcome_q       <= '0;
			frame_q         <= '0;
			k_q             <= '0;
			given_q         <= '0;
			bi_q            <= '0;
			tot_q           <= '0;
			num_q           <= '0;
			quot_q          <= '0;
			rem_q           <= '0;
			dcnt_q          <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAMES_IN_USE) begin
					frames_in_use_q <= cfg_data;
				end else if (cfg_index >= REG_LIMIT_P0 && cfg_index <= REG_LIMIT_P3) begin
					page_limit_q[2'(cfg_index - REG_LIMIT_P0)] <= cfg_data[LIMIT_W-1:0];
				end
			end

			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= in_item.mode;
						proc_q <= in_item.process;
						page_q <= in_item.page;
						outcome_q <= OUT_ENDED;
						frame_q <= '0;
						if (!quotas_ready_q) begin
							quotas_ready_q <= 1'b1;
							rs_ret_q <= 1'b1;
							state_q <= S_RS_INIT;
						end else begin
							state_q <= S_DISPATCH;
						end
					end
				end
				S_DISPATCH: begin
					fs_vld_s1 <= fs_vld_q[FW'(free_top_q)];
					ft_s1 <= FW'(free_top_q);
					i_q <= '0;
					pend_s1 <= 1'b0;
					found_q <= 1'b0;
					if (!p_ok || ended_q[p_idx]) begin
						state_q <= S_FINISH;
					end else if (mode_q) begin
						state_q <= S_REL;
					end else begin
						clock_q <= clock_q + 1'b1;
						if (32'(page_q) >= 32'(wlim[p_idx])) begin
							outcome_q <= OUT_KILLED;
							state_q <= S_REL;
						end else if (ev_q[e_addr]) begin
							state_q <= S_HIT;
						end else begin
							if (faults_q[p_idx] != '1) faults_q[p_idx] <= faults_q[p_idx] + 1'b1;
							if (free_top_q < f_eff && held_q[p_idx] < quota_q[p_idx]) begin
								state_q <= S_POP;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_HIT: begin
					outcome_q <= OUT_HIT;
					frame_q <= em_rdata.frame;
					state_q <= S_FINISH;
				end
				S_POP: begin
					free_top_q <= free_top_q + 1'b1;
					held_q[p_idx] <= held_q[p_idx] + 1'b1;
					ev_q[e_addr] <= 1'b1;
					outcome_q <= OUT_FAULT;
					frame_q <= fs_vld_s1 ? fs_rdata : ft_s1;
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					// read issued this cycle, compared the next
					if (pend_s1 && (!found_q || em_rdata.stamp < oldest_q)) begin
						found_q <= 1'b1;
						oldest_q <= em_rdata.stamp;
						victim_q <= idx_s1;
						vframe_q <= em_rdata.frame;
					end
					if (32'(i_q) < PAGES) begin
						pend_s1 <= ev_q[i_addr];
						idx_s1 <= PGW'(i_q);
						i_q <= i_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					if (found_q) begin
						ev_q[ent(p_idx, victim_q)] <= 1'b0;
						ev_q[e_addr] <= 1'b1;
						outcome_q <= OUT_FAULT;
						frame_q <= vframe_q;
					end else begin
						outcome_q <= OUT_NO_VICTIM;
					end
					state_q <= S_FINISH;
				end
				S_REL: begin
					if (32'(i_q) >= PAGES) begin
						held_q[p_idx] <= '0;
						ended_q[p_idx] <= 1'b1;
						rs_ret_q <= 1'b0;
						state_q <= S_RS_INIT;
					end else if (ev_q[i_addr]) begin
						state_q <= S_REL_PUSH;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_REL_PUSH: begin
					// frames freed while the free stack is full (free_top_q zero) are dropped
					if (free_top_q != '0) begin
						free_top_q <= free_top_q - 1'b1;
						fs_vld_q[FW'(free_top_q - FCW'(1))] <= 1'b1;
					end
					ev_q[i_addr] <= 1'b0;
					i_q <= i_q + 1'b1;
					state_q <= S_REL;
				end
				S_RS_INIT: begin
					for (int k = 0; k < PROCS; k++) begin
						if (ended_q[k]) quota_q[k] <= '0;
					end
					k_q <= '0;
					given_q <= '0;
					bi_q <= best_idx;
					tot_q <= tot;
					if (tot == '0) begin
						state_q <= rs_ret_q ? S_DISPATCH : S_FINISH;
					end else begin
						state_q <= S_RS_PROC;
					end
				end
				S_RS_PROC: begin
					if (32'(k_q) >= PROCS) begin
						state_q <= S_RS_FIX;
					end else if (ended_q[PIW'(k_q)]) begin
						k_q <= k_q + 1'b1;
					end else begin
						num_q <= NW'(f_eff) * NW'(wlim[PIW'(k_q)]);
						quot_q <= '0;
						rem_q <= '0;
						dcnt_q <= '0;
						state_q <= S_RS_DIV;
					end
				end
				S_RS_DIV: begin
					// restoring division, one quotient bit per cycle
					if (trial >= {1'b0, tot_q}) begin
						rem_q <= trial - {1'b0, tot_q};
						quot_q <= {quot_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quot_q <= {quot_q[NW-2:0], 1'b0};
					end
					num_q <= num_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (32'(dcnt_q) == NW - 1) state_q <= S_RS_STORE;
				end
				S_RS_STORE: begin
					if (quot_q == '0) begin
						quota_q[PIW'(k_q)] <= QW'(1);
						given_q <= given_q + GW'(1);
					end else begin
						quota_q[PIW'(k_q)] <= QW'(quot_q);
						given_q <= given_q + GW'(quot_q);
					end
					k_q <= k_q + 1'b1;
					state_q <= S_RS_PROC;
				end
				S_RS_FIX: begin
					if (given_q <= GW'(f_eff)) begin
						quota_q[bi_q] <= QW'(GW'(quota_q[bi_q]) + GW'(f_eff) - given_q);
					end else if (GW'(quota_q[bi_q]) > given_q - GW'(f_eff)) begin
						quota_q[bi_q] <= QW'(GW'(quota_q[bi_q]) - (given_q - GW'(f_eff)));
					end else begin
						quota_q[bi_q] <= QW'(1);
					end
					state_q <= rs_ret_q ? S_DISPATCH : S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.outcome <= outcome_q;
						out_q.frame <= 6'(frame_q);
						out_q.fault_count <= p_ok ? faults_q[p_idx] : '0;
						out_q.live_processes <= live;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- hw/rtl/dplm_ram.sv -----
module dplm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
